FILE: hw/rtl/wbbe_pkg.sv
// package for the windowed bitrate estimator
// item types, register indexes, reset values and fixed point constants
// no dependencies
`default_nettype none
package wbbe_pkg;

    localparam int FRAC_BITS = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNC_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_VAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_VAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR    = 3'd5;

    localparam logic [13:0] RST_WINDOW      = 14'd100;
    localparam logic [13:0] RST_INIT_WINDOW = 14'd500;
    localparam logic [15:0] RST_UNC_SCALE   = 16'd2560;
    localparam logic [23:0] RST_PROC_VAR    = 24'd1280;
    localparam logic [23:0] RST_FAST_VAR    = 24'd51200;
    localparam logic [23:0] RST_INIT_VAR    = 24'd12800;

    localparam logic FUNC_ACK  = 1'b0;
    localparam logic FUNC_FAST = 1'b1;

    localparam int DIV_W   = 64;
    localparam int DEN_W   = 33;
    localparam int CNT_W   = 6;

    typedef struct packed {
        logic        func;
        logic [39:0] time_ms;
        logic [15:0] byte_count;
    } t_in;

    typedef struct packed {
        logic        estimate_valid;
        logic [31:0] estimate_kbps;
        logic        sample_taken;
        logic [31:0] sample_kbps;
    } t_out;

    function automatic logic [31:0] sat32_64(input logic [63:0] v);
        sat32_64 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] sat32_33(input logic [32:0] v);
        sat32_33 = v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/windowed_bitrate_bayes_estimator.sv
// path from input accept to result valid: a fast change item goes straight to the output state,
// a packet that closes no window passes the window and check states, a window wrap or the first
// sample adds one division, and a packet that closes a window and updates the filter adds up to four
// one shared restoring divider sets the cost, at most 4 divisions per item
// one item at a time, ready only while idle; a finished item waits for a free output register
// synchronous active low reset clears window and filter state, registers take reset values
`default_nettype none
module windowed_bitrate_bayes_estimator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire wbbe_pkg::t_in               i_data,
    output logic                             o_valid,
    input  wire                              i_ready,
    output wbbe_pkg::t_out                   o_data,
    input  wire                              i_cfg_we,
    input  wire [wbbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [wbbe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_WIN   = 18'h00002,
        S_MODD  = 18'h00004,
        S_CHK   = 18'h00008,
        S_SAMPD = 18'h00010,
        S_F1    = 18'h00020,
        S_F2    = 18'h00040,
        S_F3    = 18'h00080,
        S_UD    = 18'h00100,
        S_F4    = 18'h00200,
        S_F5    = 18'h00400,
        S_F6    = 18'h00800,
        S_F7    = 18'h01000,
        S_CORRD = 18'h02000,
        S_F8    = 18'h04000,
        S_VARD  = 18'h08000,
        S_DIV   = 18'h10000,
        S_OUT   = 18'h20000
    } t_state;

    localparam int DW = wbbe_pkg::DIV_W;
    localparam int NW = wbbe_pkg::DEN_W;

    t_state r_state, n_state, r_ret, n_ret;

    logic [13:0] r_win, n_win, r_iwin, n_iwin;
    logic [15:0] r_scale, n_scale;
    logic [23:0] r_pvar, n_pvar, r_fvar, n_fvar, r_ivar, n_ivar;

    logic        r_func, n_func;
    logic [39:0] r_t, n_t;
    logic [15:0] r_bytes, n_bytes;

    logic [39:0] r_last, n_last;
    logic        r_lv, n_lv;
    logic [31:0] r_elapsed, n_elapsed, r_sum, n_sum;
    logic [31:0] r_est, n_est, r_var, n_var;
    logic        r_have, n_have;
    logic [13:0] r_w, n_w;

    logic        r_taken, n_taken;
    logic [31:0] r_sample, n_sample;
    logic [31:0] r_diff, n_diff, r_u, n_u, r_sv, n_sv, r_pv, n_pv;
    logic        r_ge, n_ge;
    logic [63:0] r_prod, n_prod;

    logic [DW-1:0] r_num, n_num, r_quo, n_quo;
    logic [NW-1:0] r_den, n_den, r_rem, n_rem;
    logic [wbbe_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic        r_ovalid, n_ovalid;
    wbbe_pkg::t_out r_out, n_out;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [NW:0] trial;
    logic        div_start;
    logic [DW-1:0] div_num;
    logic [NW-1:0] div_den;

    logic [13:0] w_sel;
    logic        back, use_gap;
    logic [39:0] gap;
    logic [40:0] total;
    logic [32:0] den_sum;

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    assign trial = {r_rem, r_num[DW-1]};

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_win = r_win;  n_iwin = r_iwin;  n_scale = r_scale;
        n_pvar = r_pvar;  n_fvar = r_fvar;  n_ivar = r_ivar;
        n_func = r_func;  n_t = r_t;  n_bytes = r_bytes;
        n_last = r_last;  n_lv = r_lv;  n_elapsed = r_elapsed;  n_sum = r_sum;
        n_est = r_est;  n_var = r_var;  n_have = r_have;  n_w = r_w;
        n_taken = r_taken;  n_sample = r_sample;  n_diff = r_diff;  n_u = r_u;
        n_sv = r_sv;  n_pv = r_pv;  n_ge = r_ge;  n_prod = r_prod;
        n_num = r_num;  n_quo = r_quo;  n_den = r_den;  n_rem = r_rem;  n_cnt = r_cnt;
        n_ovalid = r_ovalid;  n_out = r_out;
        mul_a = 32'd0;  mul_b = 32'd0;
        div_start = 1'b0;  div_num = '0;  div_den = '0;

        w_sel   = r_have ? r_win : r_iwin;
        if (w_sel == 14'd0) begin
            w_sel = 14'd1;
        end
        back    = r_lv && (r_t < r_last);
        use_gap = r_lv && !back;
        gap     = r_t - r_last;
        total   = {9'd0, r_elapsed} + {1'b0, gap};
        den_sum = {1'b0, r_sv} + {1'b0, r_pv};

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func  = i_data.func;
                    n_t     = i_data.time_ms;
                    n_bytes = i_data.byte_count;
                    n_taken = 1'b0;
                    n_sample = 32'd0;
                    if (i_data.func == wbbe_pkg::FUNC_FAST) begin
                        n_var   = wbbe_pkg::sat32_33({1'b0, r_var} + {9'd0, r_fvar});
                        n_state = S_OUT;
                    end else begin
                        n_state = S_WIN;
                    end
                end
            end
            S_WIN: begin
                n_w    = w_sel;
                n_last = r_t;
                n_lv   = 1'b1;
                n_state = S_CHK;
                if (back) begin
                    n_elapsed = 32'd0;
                    n_sum     = 32'd0;
                end
                if (use_gap) begin
                    if (gap > {26'd0, w_sel}) begin
                        n_sum     = 32'd0;
                        div_start = 1'b1;
                        div_num   = {23'd0, total};
                        div_den   = {19'd0, w_sel};
                        n_ret     = S_MODD;
                    end else begin
                        n_elapsed = wbbe_pkg::sat32_64({23'd0, total});
                    end
                end
            end
            S_MODD: begin
                n_elapsed = r_rem[31:0];
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (r_elapsed >= {18'd0, r_w}) begin
                    n_elapsed = r_elapsed - {18'd0, r_w};
                    n_sum     = {16'd0, r_bytes};
                    n_taken   = 1'b1;
                    div_start = 1'b1;
                    div_num   = {32'd0, r_sum} << (3 + wbbe_pkg::FRAC_BITS);
                    div_den   = {19'd0, r_w};
                    n_ret     = S_SAMPD;
                end else begin
                    n_sum   = wbbe_pkg::sat32_33({1'b0, r_sum} + {17'd0, r_bytes});
                    n_state = S_OUT;
                end
            end
            S_SAMPD: begin
                n_sample = wbbe_pkg::sat32_64(r_quo);
                if (!r_have) begin
                    n_est   = wbbe_pkg::sat32_64(r_quo);
                    n_have  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_F1;
                end
            end
            S_F1: begin
                n_ge    = (r_sample >= r_est);
                n_diff  = (r_sample >= r_est) ? r_sample - r_est : r_est - r_sample;
                n_state = S_F2;
            end
            S_F2: begin
                mul_a   = {16'd0, r_scale};
                mul_b   = r_diff;
                n_prod  = mul_p;
                n_state = S_F3;
            end
            S_F3: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = (r_est == 32'd0) ? {{(NW-1){1'b0}}, 1'b1} : {1'b0, r_est};
                n_ret     = S_UD;
            end
            S_UD: begin
                n_u     = wbbe_pkg::sat32_64(r_quo);
                n_state = S_F4;
            end
            S_F4: begin
                mul_a   = r_u;
                mul_b   = r_u;
                n_prod  = mul_p;
                n_state = S_F5;
            end
            S_F5: begin
                n_sv    = wbbe_pkg::sat32_64(r_prod >> wbbe_pkg::FRAC_BITS);
                n_pv    = wbbe_pkg::sat32_33({1'b0, r_var} + {9'd0, r_pvar});
                n_state = S_F6;
            end
            S_F6: begin
                if (den_sum == 33'd0) begin
                    n_var   = 32'd0;
                    n_state = S_OUT;
                end else begin
                    mul_a   = r_pv;
                    mul_b   = r_diff;
                    n_prod  = mul_p;
                    n_state = S_F7;
                end
            end
            S_F7: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = den_sum;
                n_ret     = S_CORRD;
            end
            S_CORRD: begin
                if (r_ge) begin
                    n_est = wbbe_pkg::sat32_33({1'b0, r_est} + {1'b0, r_quo[31:0]});
                end else begin
                    n_est = r_est - r_quo[31:0];
                end
                mul_a   = r_sv;
                mul_b   = r_pv;
                n_prod  = mul_p;
                n_state = S_F8;
            end
            S_F8: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = den_sum;
                n_ret     = S_VARD;
            end
            S_VARD: begin
                n_var   = wbbe_pkg::sat32_64(r_quo);
                n_state = S_OUT;
            end
            S_DIV: begin
                n_num = {r_num[DW-2:0], 1'b0};
                if (trial >= {1'b0, r_den}) begin
                    n_rem = NW'(trial - {1'b0, r_den});
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = trial[NW-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_out.estimate_valid = r_have;
                    n_out.estimate_kbps  = r_est;
                    n_out.sample_taken   = r_taken;
                    n_out.sample_kbps    = r_sample;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (div_start) begin
            n_num   = div_num;
            n_den   = div_den;
            n_rem   = '0;
            n_quo   = '0;
            n_cnt   = '1;
            n_state = S_DIV;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                wbbe_pkg::REG_WINDOW:      n_win   = i_cfg_data[13:0];
                wbbe_pkg::REG_INIT_WINDOW: n_iwin  = i_cfg_data[13:0];
                wbbe_pkg::REG_UNC_SCALE:   n_scale = i_cfg_data[15:0];
                wbbe_pkg::REG_PROC_VAR:    n_pvar  = i_cfg_data;
                wbbe_pkg::REG_FAST_VAR:    n_fvar  = i_cfg_data;
                wbbe_pkg::REG_INIT_VAR: begin
                    n_ivar = i_cfg_data;
                    if (!r_have) begin
                        n_var = {8'd0, i_cfg_data};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_win     <= wbbe_pkg::RST_WINDOW;
            r_iwin    <= wbbe_pkg::RST_INIT_WINDOW;
            r_scale   <= wbbe_pkg::RST_UNC_SCALE;
            r_pvar    <= wbbe_pkg::RST_PROC_VAR;
            r_fvar    <= wbbe_pkg::RST_FAST_VAR;
            r_ivar    <= wbbe_pkg::RST_INIT_VAR;
            r_lv      <= 1'b0;
            r_last    <= 40'd0;
            r_elapsed <= 32'd0;
            r_sum     <= 32'd0;
            r_est     <= 32'd0;
            r_var     <= {8'd0, wbbe_pkg::RST_INIT_VAR};
            r_have    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_win     <= n_win;
            r_iwin    <= n_iwin;
            r_scale   <= n_scale;
            r_pvar    <= n_pvar;
            r_fvar    <= n_fvar;
            r_ivar    <= n_ivar;
            r_lv      <= n_lv;
            r_last    <= n_last;
            r_elapsed <= n_elapsed;
            r_sum     <= n_sum;
            r_est     <= n_est;
            r_var     <= n_var;
            r_have    <= n_have;
            r_ovalid  <= n_ovalid;
        end
        r_func   <= n_func;
        r_t      <= n_t;
        r_bytes  <= n_bytes;
        r_w      <= n_w;
        r_taken  <= n_taken;
        r_sample <= n_sample;
        r_diff   <= n_diff;
        r_u      <= n_u;
        r_sv     <= n_sv;
        r_pv     <= n_pv;
        r_ge     <= n_ge;
        r_prod   <= n_prod;
        r_num    <= n_num;
        r_quo    <= n_quo;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_have_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |=> r_have)
        else $error("estimate valid flag dropped");

    a_no_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.sample_taken) |-> (o_data.sample_kbps == 32'd0))
        else $error("sample value without sample");

    a_fast_no_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_func == wbbe_pkg::FUNC_FAST) |-> !r_taken)
        else $error("fast change item took a sample");
`endif

endmodule
`default_nettype wire

FILE: verif/windowed_bitrate_bayes_estimator_test.sv
// testbench for windowed_bitrate_bayes_estimator: drives ack and fast change items,
// predicts every result in a bit-true model of window and filter, checks in order
// depends on wbbe_pkg and the estimator rtl
`timescale 1ns / 1ps
module windowed_bitrate_bayes_estimator_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLD_CYCLES    = 3000;
    localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    wbbe_pkg::t_in i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    wbbe_pkg::t_out o_data;
    logic i_cfg_we = 1'b0;
    logic [wbbe_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [wbbe_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    windowed_bitrate_bayes_estimator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic [63:0] m_window, m_init_window, m_scale, m_proc_var, m_fast_var, m_init_var;
    logic [63:0] m_last_time, m_elapsed, m_byte_sum, m_estimate, m_est_var;
    logic m_last_valid, m_have_est;

    wbbe_pkg::t_out expected_results[$];
    int mismatches = 0;
    logic no_idle = 1'b0;
    int hold_req_cnt = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    logic [39:0] cur_time = '0;

    function automatic logic [63:0] sat32(input logic [63:0] v);
        return (v > MAX32) ? MAX32 : v;
    endfunction

    function automatic wbbe_pkg::t_out predict_rate(input wbbe_pkg::t_in x);
        wbbe_pkg::t_out r;
        logic [63:0] w, t, gap, total, smp, diff, dv, u, sv, pv, den, corr;
        logic taken;
        r = '0;
        taken = 1'b0;
        smp = 0;
        if (x.func == wbbe_pkg::FUNC_FAST) begin
            m_est_var = sat32(m_est_var + m_fast_var);
        end else begin
            w = m_have_est ? m_window : m_init_window;
            if (w == 0) w = 1;
            t = {24'd0, x.time_ms};
            if (m_last_valid && t < m_last_time) begin
                m_last_valid = 1'b0;
                m_elapsed = 0;
                m_byte_sum = 0;
            end
            if (m_last_valid) begin
                gap = t - m_last_time;
                total = m_elapsed + gap;
                if (gap > w) begin
                    total = total % w;
                    m_byte_sum = 0;
                end
                m_elapsed = sat32(total);
            end
            m_last_time = t;
            m_last_valid = 1'b1;
            if (m_elapsed >= w) begin
                smp = sat32(((m_byte_sum * 8) << wbbe_pkg::FRAC_BITS) / w);
                m_elapsed = m_elapsed - w;
                m_byte_sum = 0;
                taken = 1'b1;
            end
            m_byte_sum = sat32(m_byte_sum + {48'd0, x.byte_count});
            if (taken) begin
                if (!m_have_est) begin
                    m_estimate = smp;
                    m_have_est = 1'b1;
                end else begin
                    diff = (smp >= m_estimate) ? smp - m_estimate : m_estimate - smp;
                    dv = (m_estimate == 0) ? 64'd1 : m_estimate;
                    u = sat32((m_scale * diff) / dv);
                    sv = sat32((u * u) >> wbbe_pkg::FRAC_BITS);
                    pv = sat32(m_est_var + m_proc_var);
                    den = sv + pv;
                    if (den == 0) begin
                        m_est_var = 0;
                    end else begin
                        corr = (pv * diff) / den;
                        if (smp >= m_estimate) m_estimate = sat32(m_estimate + corr);
                        else m_estimate = m_estimate - corr;
                        m_est_var = sat32((sv * pv) / den);
                    end
                end
            end
        end
        r.estimate_valid = m_have_est;
        r.estimate_kbps = m_estimate[31:0];
        r.sample_taken = taken;
        r.sample_kbps = taken ? smp[31:0] : 32'd0;
        return r;
    endfunction

    // result checking and receiver idling
    always @(posedge i_clk) begin
        wbbe_pkg::t_out exp_r;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item %p", o_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_data.estimate_valid !== exp_r.estimate_valid ||
                        o_data.estimate_kbps !== exp_r.estimate_kbps ||
                        o_data.sample_taken !== exp_r.sample_taken ||
                        o_data.sample_kbps !== exp_r.sample_kbps) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, o_data);
                    end
                end
            end
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (no_idle) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                        : $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("windowed_bitrate_bayes_estimator_test: FAIL");
            $finish;
        end
    end

    task automatic send_item(input wbbe_pkg::t_in x);
        int gap;
        @(posedge i_clk);
        i_valid <= 1'b1;
        i_data <= x;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(predict_rate(x));
        gap = 0;
        if (!no_idle) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                5, 6, 7, 8: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(20, 150);
            endcase
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap - 1) @(posedge i_clk);
        end
    endtask

    task automatic drain_items();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wbbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[wbbe_pkg::CFG_DATA_W-1:0];
        case (idx)
            wbbe_pkg::REG_WINDOW: m_window = val & 64'h3FFF;
            wbbe_pkg::REG_INIT_WINDOW: m_init_window = val & 64'h3FFF;
            wbbe_pkg::REG_UNC_SCALE: m_scale = val & 64'hFFFF;
            wbbe_pkg::REG_PROC_VAR: m_proc_var = val & 64'hFF_FFFF;
            wbbe_pkg::REG_FAST_VAR: m_fast_var = val & 64'hFF_FFFF;
            wbbe_pkg::REG_INIT_VAR: begin
                m_init_var = val & 64'hFF_FFFF;
                if (!m_have_est) m_est_var = m_init_var;
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_ack(input logic [39:0] t, input logic [15:0] b);
        wbbe_pkg::t_in x;
        x.func = wbbe_pkg::FUNC_ACK;
        x.time_ms = t;
        x.byte_count = b;
        send_item(x);
    endtask

    task automatic send_fast();
        wbbe_pkg::t_in x;
        x.func = wbbe_pkg::FUNC_FAST;
        x.time_ms = 40'({$urandom, $urandom});
        x.byte_count = 16'($urandom);
        send_item(x);
    endtask

    task automatic send_random(input int step_max);
        wbbe_pkg::t_in x;
        int r;
        r = $urandom_range(0, 99);
        x.func = wbbe_pkg::FUNC_ACK;
        if (r < 5) begin
            x.func = wbbe_pkg::FUNC_FAST;
            cur_time = cur_time;
        end else if (r < 8) begin
            cur_time = cur_time - 40'($urandom_range(1, 1000));
        end else if (r < 11) begin
            cur_time = cur_time + 40'($urandom_range(step_max * 2, step_max * 50));
        end else if (r < 13) begin
            cur_time = 40'({$urandom, $urandom});
        end else begin
            cur_time = cur_time + 40'($urandom_range(0, step_max));
        end
        x.time_ms = (x.func == wbbe_pkg::FUNC_FAST) ? 40'({$urandom, $urandom}) : cur_time;
        case ($urandom_range(0, 9))
            0: x.byte_count = 16'd0;
            1: x.byte_count = 16'hFFFF;
            default: x.byte_count = 16'($urandom);
        endcase
        send_item(x);
    endtask

    task automatic test_directed();
        send_fast();
        send_ack(40'd0, 16'hFFFF);
        send_ack(40'd250, 16'd1200);
        send_ack(40'd500, 16'd0);
        send_ack(40'd520, 16'd1500);
        send_ack(40'd600, 16'd1500);
        send_ack(40'd590, 16'd100);
        send_ack(40'd700, 16'd100);
        send_ack(40'd5000, 16'hFFFF);
        send_fast();
        send_ack(40'd5100, 16'd9);
        send_ack(40'hFF_FFFF_FFFF, 16'hFFFF);
        send_ack(40'd3, 16'd7);
        drain_items();
        // zero window lengths, zero first sample, zero weights
        write_reg(wbbe_pkg::REG_WINDOW, 0);
        write_reg(wbbe_pkg::REG_INIT_WINDOW, 0);
        write_reg(wbbe_pkg::REG_UNC_SCALE, 0);
        write_reg(wbbe_pkg::REG_PROC_VAR, 0);
        send_ack(40'd10, 16'd0);
        send_ack(40'd11, 16'd0);
        send_ack(40'd12, 16'd500);
        send_ack(40'd13, 16'hFFFF);
        send_ack(40'd14, 16'd0);
        drain_items();
    endtask

    task automatic test_random_phase(input logic [63:0] w, input logic [63:0] iw,
                                     input logic [63:0] sc, input logic [63:0] pv,
                                     input logic [63:0] fv, input logic [63:0] iv,
                                     input int n, input int step_max);
        write_reg(wbbe_pkg::REG_WINDOW, w);
        write_reg(wbbe_pkg::REG_INIT_WINDOW, iw);
        write_reg(wbbe_pkg::REG_UNC_SCALE, sc);
        write_reg(wbbe_pkg::REG_PROC_VAR, pv);
        write_reg(wbbe_pkg::REG_FAST_VAR, fv);
        write_reg(wbbe_pkg::REG_INIT_VAR, iv);
        for (int i = 0; i < n; i++) begin
            no_idle = ((i / 40) % 4 == 3);
            send_random(step_max);
        end
        no_idle = 1'b0;
        drain_items();
    endtask

    task automatic test_backpressure();
        hold_req_cnt++;
        for (int i = 0; i < 30; i++) send_random(8);
        drain_items();
    endtask

    initial begin
        int wait_cycles;
        m_window = 64'(wbbe_pkg::RST_WINDOW);
        m_init_window = 64'(wbbe_pkg::RST_INIT_WINDOW);
        m_scale = 64'(wbbe_pkg::RST_UNC_SCALE);
        m_proc_var = 64'(wbbe_pkg::RST_PROC_VAR);
        m_fast_var = 64'(wbbe_pkg::RST_FAST_VAR);
        m_init_var = 64'(wbbe_pkg::RST_INIT_VAR);
        m_last_time = 0;
        m_last_valid = 1'b0;
        m_elapsed = 0;
        m_byte_sum = 0;
        m_estimate = 0;
        m_est_var = m_init_var;
        m_have_est = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_random_phase(20, 60, 64'(wbbe_pkg::RST_UNC_SCALE), 64'(wbbe_pkg::RST_PROC_VAR),
                          64'(wbbe_pkg::RST_FAST_VAR), 64'(wbbe_pkg::RST_INIT_VAR),
                          220, 8);
        test_random_phase(1, 1, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 160, 2);
        test_random_phase(300, 16383, 1, 0, 0, 0, 140, 120);
        test_random_phase(10, 30, 0, 0, 24'hFF_FFFF, 0, 140, 4);
        test_random_phase(16383, 2, 256, 100, 5000, 400, 120, 3);
        test_backpressure();

        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("windowed_bitrate_bayes_estimator_test: PASS");
        end else begin
            $display("windowed_bitrate_bayes_estimator_test: FAIL");
        end
        $finish;
    end
endmodule
